### rtl/jhd_pkg.sv
// Shared widths, codes and interface structs for the JPEG Huffman bit decoder.
package jhd_pkg;

  localparam int DEF_MAX_CODE_LENGTH = 16;
  localparam int DEF_MAX_SYMBOLS     = 256;

  localparam int MODE_W  = 2;
  localparam int LSLOT_W = 4;
  localparam int CNT_W   = 8;
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 16;
  localparam int FIRST_W = 17;
  localparam int BASE_W  = 9;
  localparam int LEN_W   = 5;
  localparam int IDX_W   = 10;
  // Canonical code ends stay below 2^(16 + 8) even for an overfull table.
  localparam int END_W   = CODE_W + CNT_W;
  // Width of the shifted prefix compare.
  localparam int SH_W    = FIRST_W + CODE_W;

  localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SYMBOL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DECODE = 2'd2;

  // Table values looked up for the decoder's current length.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [END_W-1:0] end_len;
    logic [LEN_W-1:0] last_len;
    logic [END_W-1:0] last_end;
  } jhd_lookup_t;

  // Outcome of one decoded bit.
  typedef struct packed {
    logic             has_result;
    logic             error;
    logic [LEN_W-1:0] code_length;
    logic             sym_hit;
    logic [IDX_W-1:0] sym_addr;
  } jhd_step_t;

endpackage

### rtl/jpeg_huffman_bit_decoder.sv
// Top level of the JPEG canonical Huffman decoder that takes one coded bit per transaction.
// Canonical Huffman decoder, one coded bit per input transaction. Count loads
// set the number of codes of each length and return the decoder to the root;
// symbol loads fill the symbol table in canonical order; decode transactions
// shift in one bit, most significant first, and yield a result when a code
// completes or when the bits read begin no code (error set, symbol zero).
// Throughput is one transaction per clock while no result is stalled: the
// input register feeds the combinational decode step, whose critical path is
// the table lookup for the current length followed by the shifted prefix
// compare, and the result lands in the output register (symbol from the
// table's registered read port). A stalled result holds back only the next step.
module jpeg_huffman_bit_decoder #(
  parameter int MAX_CODE_LENGTH = jhd_pkg::DEF_MAX_CODE_LENGTH,
  parameter int MAX_SYMBOLS     = jhd_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [jhd_pkg::MODE_W-1:0]   in_mode,
  input  logic [jhd_pkg::LSLOT_W-1:0]  in_length_slot,
  input  logic [jhd_pkg::CNT_W-1:0]    in_code_count,
  input  logic [jhd_pkg::SYM_W-1:0]    in_symbol_slot,
  input  logic [jhd_pkg::SYM_W-1:0]    in_symbol_value,
  input  logic                         in_bit_req,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [jhd_pkg::SYM_W-1:0]    out_symbol,
  output logic [jhd_pkg::LEN_W-1:0]    out_code_length,
  output logic                         out_error
);

  localparam int SYM_AW = $clog2(MAX_SYMBOLS);

  logic                        in_v_r, in_v_nxt;
  logic [jhd_pkg::MODE_W-1:0]  mode_r;
  logic [jhd_pkg::LSLOT_W-1:0] lslot_r;
  logic [jhd_pkg::CNT_W-1:0]   count_r;
  logic [jhd_pkg::SYM_W-1:0]   sslot_r;
  logic [jhd_pkg::SYM_W-1:0]   sval_r;
  logic                        bit_r;

  logic                        out_v_r, out_v_nxt;
  logic [jhd_pkg::LEN_W-1:0]   len_out_r;
  logic                        err_out_r;
  logic                        sym_zero_r;

  logic                        accept;
  logic                        fire;
  logic                        count_load;
  logic                        sym_load;
  logic                        dec_en;
  logic                        result;
  logic [jhd_pkg::LEN_W-1:0]   bits_read;
  logic [jhd_pkg::SYM_W-1:0]   sym_rd;
  jhd_pkg::jhd_lookup_t        lookup;
  jhd_pkg::jhd_step_t          step;

  assign fire       = in_v_r && (!out_v_r || !out_stall);
  assign in_stall   = in_v_r && !fire;
  assign accept     = in_valid && !in_stall;
  assign count_load = fire && (mode_r == jhd_pkg::MODE_COUNT)
                    && ({1'b0, lslot_r} < (jhd_pkg::LSLOT_W + 1)'(MAX_CODE_LENGTH));
  assign sym_load   = fire && (mode_r == jhd_pkg::MODE_SYMBOL)
                    && ({1'b0, sslot_r} < (jhd_pkg::SYM_W + 1)'(MAX_SYMBOLS));
  assign dec_en     = fire && (mode_r == jhd_pkg::MODE_DECODE);
  assign result     = dec_en && step.has_result;

  always_comb begin
    in_v_nxt = in_v_r;
    if (accept) begin
      in_v_nxt = 1'b1;
    end else if (fire) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (fire) begin
      out_v_nxt = result;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      lslot_r <= in_length_slot;
      count_r <= in_code_count;
      sslot_r <= in_symbol_slot;
      sval_r  <= in_symbol_value;
      bit_r   <= in_bit_req;
    end
    if (result) begin
      len_out_r  <= step.code_length;
      err_out_r  <= step.error;
      sym_zero_r <= !step.sym_hit;
    end
  end

  jhd_table #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (count_load),
    .load_slot (lslot_r),
    .load_count(count_r),
    .rd_len_idx(bits_read),
    .lookup    (lookup)
  );

  jhd_decode #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH),
    .MAX_SYMBOLS    (MAX_SYMBOLS)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .dec_en   (dec_en),
    .root_req (count_load),
    .bit_in   (bit_r),
    .lookup   (lookup),
    .bits_read(bits_read),
    .step     (step)
  );

  jhd_symtab #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_symtab (
    .clk    (clk),
    .wr_en  (sym_load),
    .wr_addr(sslot_r[SYM_AW-1:0]),
    .wr_data(sval_r),
    .rd_en  (result && step.sym_hit),
    .rd_addr(step.sym_addr[SYM_AW-1:0]),
    .rd_data(sym_rd)
  );

  assign out_valid       = out_v_r;
  assign out_symbol      = sym_zero_r ? '0 : sym_rd;
  assign out_code_length = len_out_r;
  assign out_error       = err_out_r;

`ifndef SYNTH
  // The input side only waits behind a result that is itself held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_v_r && out_stall))
    else $error("input stalled without a held result");

  // A finished code or an error shows up as a result in the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    result |=> out_valid)
    else $error("decode result was lost");

  // An error result never carries a symbol.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_symbol == '0))
    else $error("error result with nonzero symbol");

  // Reported code lengths stay within the supported range.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_code_length != '0)
      && (out_code_length <= jhd_pkg::LEN_W'(MAX_CODE_LENGTH))))
    else $error("code length out of range");
`endif

endmodule

### rtl/jhd_table.sv
// Code count registers and the running canonical code end for every length.
module jhd_table #(
  parameter int MAX_CODE_LENGTH = jhd_pkg::DEF_MAX_CODE_LENGTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load_en,
  input  logic [jhd_pkg::LSLOT_W-1:0] load_slot,
  input  logic [jhd_pkg::CNT_W-1:0]   load_count,
  input  logic [jhd_pkg::LEN_W-1:0]   rd_len_idx,
  output jhd_pkg::jhd_lookup_t        lookup
);

  localparam int CIW = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;

  logic [jhd_pkg::CNT_W-1:0] counts_r   [MAX_CODE_LENGTH];
  logic [jhd_pkg::CNT_W-1:0] counts_nxt [MAX_CODE_LENGTH];
  logic [jhd_pkg::END_W-1:0] ends_r     [MAX_CODE_LENGTH];
  logic [jhd_pkg::END_W-1:0] ends_nxt   [MAX_CODE_LENGTH];
  logic [jhd_pkg::END_W-1:0] delta;
  logic [jhd_pkg::LEN_W-1:0] shamt;

  // A new count for length k moves the end of every length L >= k by
  // (new - old) << (L - k); the sum wraps exactly in two's complement.
  always_comb begin
    delta = {{(jhd_pkg::END_W - jhd_pkg::CNT_W){1'b0}}, load_count}
          - {{(jhd_pkg::END_W - jhd_pkg::CNT_W){1'b0}}, counts_r[load_slot[CIW-1:0]]};
    shamt = '0;
    for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
      counts_nxt[i] = counts_r[i];
      ends_nxt[i]   = ends_r[i];
      shamt = jhd_pkg::LEN_W'(i) - {1'b0, load_slot};
      if (load_en) begin
        if (jhd_pkg::LEN_W'(i) == {1'b0, load_slot}) begin
          counts_nxt[i] = load_count;
        end
        if (jhd_pkg::LEN_W'(i) >= {1'b0, load_slot}) begin
          ends_nxt[i] = ends_r[i] + (delta << shamt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
        counts_r[i] <= '0;
        ends_r[i]   <= '0;
      end
    end else begin
      for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
        counts_r[i] <= counts_nxt[i];
        ends_r[i]   <= ends_nxt[i];
      end
    end
  end

  always_comb begin
    lookup.count    = counts_r[rd_len_idx[CIW-1:0]];
    lookup.end_len  = ends_r[rd_len_idx[CIW-1:0]];
    lookup.last_len = '0;
    lookup.last_end = '0;
    for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
      if (counts_r[i] != '0) begin
        lookup.last_len = jhd_pkg::LEN_W'(i + 1);
        lookup.last_end = ends_r[i];
      end
    end
  end

endmodule

### rtl/jhd_decode.sv
// Code walk state and the one-bit decode step against the canonical ranges.
module jhd_decode #(
  parameter int MAX_CODE_LENGTH = jhd_pkg::DEF_MAX_CODE_LENGTH,
  parameter int MAX_SYMBOLS     = jhd_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      dec_en,
  input  logic                      root_req,
  input  logic                      bit_in,
  input  jhd_pkg::jhd_lookup_t      lookup,
  output logic [jhd_pkg::LEN_W-1:0] bits_read,
  output jhd_pkg::jhd_step_t        step
);

  logic [jhd_pkg::CODE_W-1:0]  code_so_far_r, code_so_far_nxt;
  logic [jhd_pkg::LEN_W-1:0]   bits_read_r, bits_read_nxt;
  logic [jhd_pkg::FIRST_W-1:0] first_code_r, first_code_nxt;
  logic [jhd_pkg::BASE_W-1:0]  base_index_r, base_index_nxt;

  logic [jhd_pkg::LEN_W-1:0]   len;
  logic [jhd_pkg::FIRST_W-1:0] code;
  logic [jhd_pkg::FIRST_W-1:0] diff;
  logic [jhd_pkg::FIRST_W:0]   code_end;
  logic [jhd_pkg::FIRST_W-1:0] gap;
  logic [jhd_pkg::LEN_W-1:0]   shamt;
  logic [jhd_pkg::END_W-1:0]   rest;
  logic [jhd_pkg::SH_W-1:0]    gap_sh;
  logic                        match;
  logic                        extend;

  always_comb begin
    len      = bits_read_r + jhd_pkg::LEN_W'(1);
    code     = {code_so_far_r, bit_in};
    diff     = code - first_code_r;
    code_end = {1'b0, first_code_r} + {{(jhd_pkg::FIRST_W + 1 - jhd_pkg::CNT_W){1'b0}},
                                       lookup.count};
    match    = (len <= jhd_pkg::LEN_W'(MAX_CODE_LENGTH)) && (code >= first_code_r)
             && (diff < {{(jhd_pkg::FIRST_W - jhd_pkg::CNT_W){1'b0}}, lookup.count});

    // A longer code starts with this prefix when, at the last length that
    // has codes, the prefix extended with zeros still lies below that end.
    gap    = code - code_end[jhd_pkg::FIRST_W-1:0];
    shamt  = lookup.last_len - len;
    rest   = lookup.last_end - (lookup.end_len << shamt);
    gap_sh = {{(jhd_pkg::SH_W - jhd_pkg::FIRST_W){1'b0}}, gap} << shamt;
    extend = (len < jhd_pkg::LEN_W'(MAX_CODE_LENGTH))
           && ({1'b0, code} >= code_end)
           && (lookup.last_len > len)
           && (gap_sh < {{(jhd_pkg::SH_W - jhd_pkg::END_W){1'b0}}, rest});

    step.has_result  = match || !extend;
    step.error       = !match && !extend;
    step.code_length = len;
    step.sym_addr    = {1'b0, base_index_r}
                     + {{(jhd_pkg::IDX_W - jhd_pkg::CNT_W){1'b0}}, diff[jhd_pkg::CNT_W-1:0]};
    step.sym_hit     = match && (step.sym_addr < jhd_pkg::IDX_W'(MAX_SYMBOLS));

    code_so_far_nxt = code_so_far_r;
    bits_read_nxt   = bits_read_r;
    first_code_nxt  = first_code_r;
    base_index_nxt  = base_index_r;
    if (root_req || (dec_en && step.has_result)) begin
      code_so_far_nxt = '0;
      bits_read_nxt   = '0;
      first_code_nxt  = '0;
      base_index_nxt  = '0;
    end else if (dec_en) begin
      code_so_far_nxt = code[jhd_pkg::CODE_W-1:0];
      bits_read_nxt   = len;
      first_code_nxt  = {code_end[jhd_pkg::FIRST_W-2:0], 1'b0};
      base_index_nxt  = base_index_r + {{(jhd_pkg::BASE_W - jhd_pkg::CNT_W){1'b0}},
                                        lookup.count};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_so_far_r <= '0;
      bits_read_r   <= '0;
      first_code_r  <= '0;
      base_index_r  <= '0;
    end else begin
      code_so_far_r <= code_so_far_nxt;
      bits_read_r   <= bits_read_nxt;
      first_code_r  <= first_code_nxt;
      base_index_r  <= base_index_nxt;
    end
  end

  assign bits_read = bits_read_r;

endmodule

### rtl/jhd_symtab.sv
// Symbol table memory with one write port and one registered read port.
module jhd_symtab #(
  parameter int MAX_SYMBOLS = jhd_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(MAX_SYMBOLS)-1:0]   wr_addr,
  input  logic [jhd_pkg::SYM_W-1:0]        wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(MAX_SYMBOLS)-1:0]   rd_addr,
  output logic [jhd_pkg::SYM_W-1:0]        rd_data
);

  logic [jhd_pkg::SYM_W-1:0] mem [MAX_SYMBOLS];
  logic [jhd_pkg::SYM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
